/* sv/ghp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package ghp_pkg;

    typedef enum logic [2:0] {
        CMD_ADD    = 3'd0,
        CMD_REMOVE = 3'd1,
        CMD_CHECK  = 3'd2,
        CMD_HEAD   = 3'd3,
        CMD_TAIL   = 3'd4,
        CMD_NEXT   = 3'd5,
        CMD_PREV   = 3'd6,
        CMD_NONE   = 3'd7
    } cmd_t;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_STALE = 2'd2;

    localparam logic [15:0] GEN_LIMIT_RESET = 16'hFFFF;

    typedef struct packed {
        logic [2:0]  command;
        logic [7:0]  handle_index;
        logic [15:0] handle_generation;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        found;
        logic [7:0]  out_index;
        logic [15:0] out_generation;
    } rsp_t;

endpackage
`default_nettype wire

/* sv/ghp_gen_step.sv */
`timescale 1ns / 1ps
`default_nettype none
// Next generation: max(1, (g + 1) mod limit), limit 0 taken as 1.
// The quotient of (g+1)/limit is at most 65536, so the remainder comes from
// a restoring divider that retires one bit a cycle.
module ghp_gen_step (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [15:0] gen_in,
    input  wire logic [15:0] limit,
    output logic             done,
    output logic [15:0]      gen_out
);
    logic [16:0] dividend_reg;
    logic [16:0] rem_reg;
    logic [15:0] div_reg;
    logic [4:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [17:0] trial;

    assign trial = {rem_reg, dividend_reg[16]} - {2'b00, div_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg     <= 1'b1;
                cnt_reg      <= 5'd17;
                dividend_reg <= {1'b0, gen_in} + 17'd1;
                rem_reg      <= '0;
                div_reg      <= (limit == 16'd0) ? 16'd1 : limit;
            end else if (busy_reg) begin
                dividend_reg <= {dividend_reg[15:0], 1'b0};
                if (!trial[17]) begin
                    rem_reg <= trial[16:0];
                end else begin
                    rem_reg <= {rem_reg[15:0], dividend_reg[16]};
                end
                cnt_reg <= cnt_reg - 5'd1;
                if (cnt_reg == 5'd1) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done    = done_reg;
    assign gen_out = (rem_reg[15:0] == 16'd0) ? 16'd1 : rem_reg[15:0];
endmodule
`default_nettype wire

/* sv/generational_handle_pool_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// Generational handle pool. Input channel s_* carries a command (add, remove,
// check, head, tail, next, prev) with a handle; result channel m_* returns one
// result per command with status, found, index and generation.
// cfg_we/cfg_wdata write the generation limit; write only while idle.
// Commands run one at a time: s_ready is low from acceptance until the command
// hands its result to the output register. Check, head, tail and rejected
// commands answer after the table read and evaluation; next and prev take one
// more table read, remove frees the slot and then patches the neighbour and
// free-head links in turn, and add waits for the one-bit-a-cycle remainder unit
// to give the generation wrap before it writes the tables. The next command can
// be taken in the same cycle in which the result appears.
// After reset a clearing pass over all SLOT_COUNT slots rebuilds the link
// tables and zeroes generations and live bits; s_ready stays low meanwhile.
// A stalled receiver holds the result in the output register; one more command
// is taken and worked, then waits until the output register is free.
module generational_handle_pool_core #(
    parameter int SLOT_COUNT = 256
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire ghp_pkg::req_t     s_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output ghp_pkg::rsp_t          m_data,
    input  wire logic              cfg_we,
    input  wire logic [15:0]       cfg_wdata
);
    localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int LW = $clog2(SLOT_COUNT + 1);
    localparam logic [LW-1:0] NONE = LW'(SLOT_COUNT);
    localparam logic [LW-1:0] LAST = LW'(SLOT_COUNT - 1);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_RD, S_EVAL, S_GEN, S_ADD_W,
        S_RM_W, S_RM_A, S_RM_B, S_RM_C, S_RESP
    } state_t;

    // Memories with one write port and one registered read port at addr
    logic [LW-1:0] next_mem [SLOT_COUNT];
    logic [LW-1:0] prev_mem [SLOT_COUNT];
    logic [15:0]   gen_mem  [SLOT_COUNT];
    logic          live_mem [SLOT_COUNT];

    state_t        state_reg;
    logic [LW-1:0] clr_reg;
    logic [15:0]   limit_reg;
    ghp_pkg::req_t req_reg;
    ghp_pkg::rsp_t rsp_reg;
    ghp_pkg::rsp_t out_reg;
    logic          m_valid_reg;
    logic [LW-1:0] free_first_reg, free_last_reg, used_first_reg, used_last_reg;
    logic [LW-1:0] slot_reg;
    logic [LW-1:0] nx_reg, pv_reg;
    logic [LW-1:0] rsp_slot_reg;
    logic          rsp_rd_reg;
    // Tail and free-head snapshots taken in S_EVAL for the deferred link writes
    logic [LW-1:0] used_prev_tail_reg;
    logic [LW-1:0] old_free_reg;

    logic [LW-1:0] nx_rd, pv_rd;
    logic [15:0]   g_rd;
    logic          live_rd;
    logic [IW-1:0] addr;
    logic          gs_start, gs_done;
    logic [15:0]   gs_out;

    logic          eval_vh;
    logic [LW-1:0] eval_link;
    logic          eval_walk;
    state_t        eval_state;
    ghp_pkg::rsp_t eval_rsp;
    ghp_pkg::rsp_t rsp_final;
    logic          resp_fire;

    ghp_gen_step u_gen (
        .aclk(aclk), .aresetn(aresetn), .start(gs_start),
        .gen_in(g_rd), .limit(limit_reg), .done(gs_done), .gen_out(gs_out)
    );

    assign addr = slot_reg[IW-1:0];
    assign gs_start = (state_reg == S_EVAL) && (req_reg.command == ghp_pkg::CMD_ADD)
                      && (slot_reg != NONE);

    assign eval_vh   = (slot_reg < NONE) && live_rd && (g_rd != 16'd0)
                       && (g_rd == req_reg.handle_generation);
    assign eval_link = (req_reg.command == ghp_pkg::CMD_NEXT) ? nx_rd : pv_rd;

    always_comb begin
        eval_rsp   = '0;
        eval_state = S_RESP;
        eval_walk  = 1'b0;
        unique case (ghp_pkg::cmd_t'(req_reg.command))
            ghp_pkg::CMD_ADD: begin
                if (slot_reg == NONE) begin
                    eval_rsp.status = ghp_pkg::ST_FULL;
                end else begin
                    eval_state = S_GEN;
                end
            end
            ghp_pkg::CMD_REMOVE: begin
                if (eval_vh) begin
                    eval_state = S_RM_W;
                end else begin
                    eval_rsp.status = ghp_pkg::ST_STALE;
                end
            end
            ghp_pkg::CMD_CHECK: begin
                eval_rsp.status = eval_vh ? ghp_pkg::ST_OK : ghp_pkg::ST_STALE;
            end
            ghp_pkg::CMD_HEAD, ghp_pkg::CMD_TAIL: begin
                if (slot_reg != NONE) begin
                    eval_rsp.found          = 1'b1;
                    eval_rsp.out_index      = 8'(slot_reg);
                    eval_rsp.out_generation = g_rd;
                end
            end
            ghp_pkg::CMD_NEXT, ghp_pkg::CMD_PREV: begin
                // read the linked slot's generation before answering
                if (eval_vh) begin
                    eval_walk = 1'b1;
                end else begin
                    eval_rsp.status = ghp_pkg::ST_STALE;
                end
            end
            default: eval_rsp.status = ghp_pkg::ST_STALE;
        endcase
    end

    always_comb begin
        rsp_final = rsp_reg;
        if (rsp_slot_reg != NONE) begin
            rsp_final.found          = 1'b1;
            rsp_final.out_index      = 8'(rsp_slot_reg);
            rsp_final.out_generation = g_rd;
        end
    end

    assign resp_fire = (state_reg == S_RESP) && !rsp_rd_reg && (!m_valid_reg || m_ready);

    always_ff @(posedge aclk) begin
        nx_rd   <= next_mem[addr];
        pv_rd   <= prev_mem[addr];
        g_rd    <= gen_mem[addr];
        live_rd <= live_mem[addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_CLEAR;
            clr_reg        <= '0;
            limit_reg      <= ghp_pkg::GEN_LIMIT_RESET;
            m_valid_reg    <= 1'b0;
            free_first_reg <= '0;
            free_last_reg  <= LAST;
            used_first_reg <= NONE;
            used_last_reg  <= NONE;
            rsp_rd_reg     <= 1'b0;
            rsp_slot_reg   <= NONE;
        end else begin
            if (cfg_we) begin
                limit_reg <= cfg_wdata;
            end
            if (resp_fire) begin
                m_valid_reg <= 1'b1;
                out_reg     <= rsp_final;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_CLEAR: begin
                    next_mem[clr_reg[IW-1:0]] <= clr_reg + LW'(1);
                    prev_mem[clr_reg[IW-1:0]] <= (clr_reg == '0) ? NONE : clr_reg - LW'(1);
                    gen_mem[clr_reg[IW-1:0]]  <= '0;
                    live_mem[clr_reg[IW-1:0]] <= 1'b0;
                    clr_reg <= clr_reg + LW'(1);
                    if (clr_reg == LAST) begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (s_valid) begin
                        req_reg <= s_data;
                        unique case (ghp_pkg::cmd_t'(s_data.command))
                            ghp_pkg::CMD_ADD:  slot_reg <= free_first_reg;
                            ghp_pkg::CMD_HEAD: slot_reg <= used_first_reg;
                            ghp_pkg::CMD_TAIL: slot_reg <= used_last_reg;
                            default: slot_reg <= (s_data.handle_index < SLOT_COUNT)
                                                 ? LW'(s_data.handle_index) : NONE;
                        endcase
                        state_reg <= S_RD;
                    end
                end
                S_RD: begin
                    state_reg <= S_EVAL;
                end
                S_EVAL: begin
                    nx_reg       <= nx_rd;
                    pv_reg       <= pv_rd;
                    rsp_reg      <= eval_rsp;
                    state_reg    <= eval_state;
                    rsp_rd_reg   <= eval_walk;
                    rsp_slot_reg <= eval_walk ? eval_link : NONE;
                    if (eval_walk) begin
                        slot_reg <= eval_link;
                    end
                end
                S_GEN: begin
                    if (gs_done) begin
                        // unlink free head, mark live, append to used tail
                        gen_mem[addr]  <= gs_out;
                        live_mem[addr] <= 1'b1;
                        next_mem[addr] <= NONE;
                        prev_mem[addr] <= used_last_reg;
                        free_first_reg <= nx_reg;
                        if (free_last_reg == slot_reg) begin
                            free_last_reg <= pv_reg;
                        end
                        if (used_last_reg == NONE) begin
                            used_first_reg <= slot_reg;
                        end
                        used_last_reg <= slot_reg;
                        rsp_reg <= '{status: ghp_pkg::ST_OK, found: 1'b1,
                                     out_index: 8'(slot_reg), out_generation: gs_out};
                        state_reg <= S_ADD_W;
                    end
                end
                S_ADD_W: begin
                    // free head was free_first so its prev is none already
                    if (nx_reg != NONE) begin
                        prev_mem[nx_reg[IW-1:0]] <= NONE;
                    end
                    if (used_prev_tail_reg != NONE) begin
                        next_mem[used_prev_tail_reg[IW-1:0]] <= slot_reg;
                    end
                    state_reg <= S_RESP;
                end
                S_RM_W: begin
                    live_mem[addr] <= 1'b0;
                    next_mem[addr] <= free_first_reg;
                    prev_mem[addr] <= NONE;
                    if (used_first_reg == slot_reg) used_first_reg <= nx_reg;
                    if (used_last_reg == slot_reg)  used_last_reg  <= pv_reg;
                    free_first_reg <= slot_reg;
                    if (free_first_reg == NONE) free_last_reg <= slot_reg;
                    state_reg <= S_RM_A;
                end
                S_RM_A: begin
                    if (pv_reg != NONE) next_mem[pv_reg[IW-1:0]] <= nx_reg;
                    state_reg <= S_RM_B;
                end
                S_RM_B: begin
                    if (nx_reg != NONE) prev_mem[nx_reg[IW-1:0]] <= pv_reg;
                    state_reg <= S_RM_C;
                end
                S_RM_C: begin
                    if (old_free_reg != NONE) prev_mem[old_free_reg[IW-1:0]] <= slot_reg;
                    rsp_reg.status <= ghp_pkg::ST_OK;
                    state_reg <= S_RESP;
                end
                S_RESP: begin
                    if (rsp_rd_reg) begin
                        rsp_rd_reg <= 1'b0;
                    end else if (resp_fire) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_EVAL) begin
            used_prev_tail_reg <= used_last_reg;
            old_free_reg       <= free_first_reg;
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    property p_no_accept_busy;
        @(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready;
    endproperty
    a_no_accept_busy: assert property (p_no_accept_busy) else $error("accept while busy");

    property p_found_gen;
        @(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.found) |-> (m_data.out_index == 8'd0 && m_data.out_generation == 16'd0);
    endproperty
    a_found_gen: assert property (p_found_gen) else $error("data without slot");

    property p_add_gen;
        @(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.found && m_data.status == ghp_pkg::ST_OK) |-> (m_data.out_generation != 16'd0);
    endproperty
    a_add_gen: assert property (p_add_gen) else $error("zero generation returned");
endmodule
`default_nettype wire
